@@ sv/sbm_pkg.sv @@
// Shared constants for the shadow bitmap mark/check unit: field widths,
// command codes and parameter defaults. No dependencies.
`default_nettype none
package sbm_pkg;

  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 16;
  localparam int SIZE_W     = 11;
  localparam int BYTE_W     = 8;
  localparam int BIT_IX_W   = 3;
  localparam int S_DATA_W   = 32;
  localparam int M_DATA_W   = 16;

  localparam int DEF_ADDR_BITS = 16;
  localparam int DEF_MAX_SIZE  = 1024;

  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_MARK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNMARK = 2'd2;

endpackage
`default_nettype wire

@@ sv/sbm_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
// Stand-alone; no package dependencies.
`default_nettype none
module sbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ sv/shadow_bitmap_mark_check_unit.sv @@
// Top level of the shadow bitmap mark/check unit: request decode, byte walk
// sequencer and result register. Depends on sbm_pkg and sbm_ram.
//
// Usage:
//   Requests enter on the s_* stream (command, addr, size in s_tdata); one
//   result leaves per request on the m_* stream (set_count in m_tdata,
//   range_error in m_tuser). The bitmap holds one bit per byte of a space of
//   2^ADDR_BITS bytes, stored as 2^(ADDR_BITS-3) bytes in one RAM.
//   After reset the RAM is swept to zero, one byte per cycle, and s_tready
//   stays low meanwhile. A request touching n bitmap bytes, with
//   n = ((addr+size-1)>>3)-(addr>>3)+1, streams reads at one byte per cycle,
//   each byte's read-modify-write following in the cycle after its read;
//   its result is then registered, and the next request is taken only once
//   that result has moved into the output register. Rejected ranges, empty
//   ranges and unknown commands skip the walk: their result is registered
//   directly on acceptance, without reading or writing the RAM.
//   A finished result waits in the output register while the next request
//   is accepted; a stalled receiver holds the walk only once the next
//   result is ready to be registered.
`default_nettype none
module shadow_bitmap_mark_check_unit #(
  parameter int ADDR_BITS = sbm_pkg::DEF_ADDR_BITS,
  parameter int MAX_SIZE  = sbm_pkg::DEF_MAX_SIZE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [1:0] command, [17:2] addr, [28:18] size, [31:29] zero
  input  logic [sbm_pkg::S_DATA_W-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [10:0] set_count, [15:11] zero
  output logic [sbm_pkg::M_DATA_W-1:0] m_tdata,
  // [0] range_error
  output logic                         m_tuser
);

  import sbm_pkg::*;

  localparam int MAP_BITS  = ADDR_BITS - 3;
  localparam int MAP_DEPTH = 1 << MAP_BITS;
  localparam int END_W     = ((ADDR_BITS > ADDR_W) ? ADDR_BITS : ADDR_W) + 1;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_WALK   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]          state;
  logic [MAP_BITS-1:0] clr_idx;
  logic [CMD_W-1:0]    cmd_r;
  logic [SIZE_W-1:0]   size_r;
  logic [MAP_BITS-1:0] issue_idx;
  logic [MAP_BITS-1:0] last_idx;
  logic [BIT_IX_W-1:0] first_lo;
  logic [BIT_IX_W-1:0] last_hi;
  logic                issue_on;
  logic                issue_first;
  logic                s2_valid;
  logic [MAP_BITS-1:0] s2_idx;
  logic                s2_first;
  logic                s2_last;
  logic [SIZE_W-1:0]   count;
  logic [SIZE_W-1:0]   res_count;
  logic                res_err;

  logic [CMD_W-1:0]    in_cmd;
  logic [ADDR_W-1:0]   in_addr;
  logic [SIZE_W-1:0]   in_size;
  logic [END_W-1:0]    addr_ext;
  logic [END_W-1:0]    end_sum;
  logic [END_W-1:0]    last_ext;
  logic                in_err;
  logic                in_walk;
  logic                accept;

  logic                wr_en;
  logic [MAP_BITS-1:0] wr_addr;
  logic [BYTE_W-1:0]   wr_data;
  logic [BYTE_W-1:0]   rd_data;
  logic [BIT_IX_W-1:0] mask_lo;
  logic [BIT_IX_W-1:0] mask_hi;
  logic [BYTE_W-1:0]   mask;
  logic [BIT_IX_W:0]   pop;
  logic [SIZE_W-1:0]   count_next;

  assign in_cmd   = s_tdata[CMD_W-1:0];
  assign in_addr  = s_tdata[CMD_W +: ADDR_W];
  assign in_size  = s_tdata[CMD_W+ADDR_W +: SIZE_W];
  assign addr_ext = END_W'(in_addr);
  assign end_sum  = addr_ext + END_W'(in_size);
  assign last_ext = end_sum - END_W'(1);
  assign in_err   = (32'(in_size) > 32'(MAX_SIZE)) ||
                    (end_sum > (END_W'(1) << ADDR_BITS));
  assign in_walk  = !in_err && (in_size != '0) &&
                    (in_cmd == CMD_CHECK || in_cmd == CMD_MARK || in_cmd == CMD_UNMARK);

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  assign mask_lo = s2_first ? first_lo : '0;
  assign mask_hi = s2_last ? last_hi : '1;

  always_comb begin
    pop = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      mask[b] = (BIT_IX_W'(b) >= mask_lo) && (BIT_IX_W'(b) <= mask_hi);
      pop = pop + (BIT_IX_W+1)'(mask[b] & rd_data[b]);
    end
  end

  assign count_next = count + SIZE_W'(pop);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s2_idx;
    wr_data = rd_data & ~mask;
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_data = '0;
    end else if (state == ST_WALK && s2_valid && cmd_r != CMD_CHECK) begin
      wr_en = 1'b1;
      if (cmd_r == CMD_MARK) begin
        wr_data = rd_data | mask;
      end
    end
  end

  sbm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (issue_idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      issue_on <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + MAP_BITS'(1);
          if (clr_idx == MAP_BITS'(MAP_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_r  <= in_cmd;
            size_r <= in_size;
            if (in_walk) begin
              issue_idx   <= addr_ext[ADDR_BITS-1:3];
              last_idx    <= last_ext[ADDR_BITS-1:3];
              first_lo    <= addr_ext[BIT_IX_W-1:0];
              last_hi     <= last_ext[BIT_IX_W-1:0];
              issue_on    <= 1'b1;
              issue_first <= 1'b1;
              count       <= '0;
              state       <= ST_WALK;
            end else begin
              res_count <= '0;
              res_err   <= in_err;
              state     <= ST_FINISH;
            end
          end
        end
        ST_WALK: begin
          s2_valid <= issue_on;
          if (issue_on) begin
            s2_idx      <= issue_idx;
            s2_first    <= issue_first;
            s2_last     <= (issue_idx == last_idx);
            issue_first <= 1'b0;
            issue_idx   <= issue_idx + MAP_BITS'(1);
            if (issue_idx == last_idx) begin
              issue_on <= 1'b0;
            end
          end
          if (s2_valid) begin
            count <= count_next;
            if (s2_last) begin
              res_count <= (cmd_r == CMD_CHECK) ? count_next : '0;
              res_err   <= 1'b0;
              state     <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= M_DATA_W'(res_count);
            m_tuser  <= res_err;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_stage_in_walk: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (state == ST_WALK))
    else $error("read-modify-write stage active outside walk");

  a_err_skips_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && in_err) |=> (state == ST_FINISH && res_err && res_count == '0))
    else $error("rejected range not answered directly");

  a_mark_keeps_bits: assert property (@(posedge clk) disable iff (rst)
    (wr_en && state == ST_WALK && cmd_r == CMD_MARK) |-> ((wr_data & rd_data) == rd_data))
    else $error("mark cleared a bit");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> (res_count <= size_r))
    else $error("set count exceeds range length");

  a_clear_writes_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> (wr_en && wr_data == '0 && !s_tready))
    else $error("clearing pass not writing zeros");
`endif

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for shadow_bitmap_mark_check_unit: directed and random check/mark/unmark
// and unknown-command requests, predicted by a bitmap scoreboard and compared result by result.
// Depends on sbm_pkg and the unit's RTL.
import sbm_pkg::*;

localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
localparam int SPACE_BYTES = 1 << DEF_ADDR_BITS;
localparam int MAP_BYTES = 1 << (DEF_ADDR_BITS - BIT_IX_W);

typedef struct packed {
  logic [SIZE_W-1:0] set_count;
  logic range_error;
} bitmap_result_t;

class bitmap_scoreboard;
  bit [BYTE_W-1:0] shadow [MAP_BYTES];
  bitmap_result_t expected_q[$];
  int errors;
  int n_checks, n_marks, n_unmarks, n_rejects, n_unknown, n_results;

  function void note_request(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [SIZE_W-1:0] size);
    bitmap_result_t exp;
    int a;
    exp = '0;
    if (size > DEF_MAX_SIZE || int'(addr) + int'(size) > SPACE_BYTES) begin
      exp.range_error = 1'b1;
      n_rejects++;
    end else if (cmd == CMD_UNKNOWN) begin
      n_unknown++;
    end else begin
      for (int k = 0; k < size; k++) begin
        a = int'(addr) + k;
        case (cmd)
          CMD_CHECK: if (shadow[a >> 3][a & 7]) exp.set_count++;
          CMD_MARK: shadow[a >> 3][a & 7] = 1'b1;
          default: shadow[a >> 3][a & 7] = 1'b0;
        endcase
      end
      case (cmd)
        CMD_CHECK: n_checks++;
        CMD_MARK: n_marks++;
        default: n_unmarks++;
      endcase
    end
    expected_q.push_back(exp);
  endfunction

  function void check_result(input logic [SIZE_W-1:0] count, input logic err);
    bitmap_result_t exp;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, set_count %0d range_error %0d", $time, count, err);
      errors++;
      return;
    end
    exp = expected_q.pop_front();
    n_results++;
    if (count !== exp.set_count) begin
      $display("%0t: set_count expected %0d, actual %0d", $time, exp.set_count, count);
      errors++;
    end
    if (err !== exp.range_error) begin
      $display("%0t: range_error expected %0d, actual %0d", $time, exp.range_error, err);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int N_RANDOM = 1430;
  localparam int HOLD_OFF_CYCLES = 400;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic m_tuser;

  bitmap_scoreboard sb = new();
  int n_accepted = 0;

  shadow_bitmap_mark_check_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[SIZE_W-1:0], m_tuser);
  end

  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: stall pattern drawn at random from four modes, one long hold-off mid-run
  initial begin
    int cyc;
    int rx_mode;
    bit hold_done;
    cyc = 0;
    rx_mode = 0;
    hold_done = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 50 == 0) rx_mode = $urandom_range(0, 3);
      if (!hold_done && n_accepted >= 600) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        case (rx_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (cyc % 5 == 0);
          default: m_tready <= (cyc % 7 != 0);
        endcase
      end
    end
  end

  task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                          input logic [SIZE_W-1:0] size, input int gap);
    s_tvalid <= 1'b1;
    s_tdata <= {{(S_DATA_W - CMD_W - ADDR_W - SIZE_W){1'b0}}, size, addr, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(cmd, addr, size);
    n_accepted++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [CMD_W-1:0] cmd;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    int r;
    int window_base;
    int burst_left;
    int gap;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    push_req(CMD_CHECK, 16'd0, 11'd0, 0);
    push_req(CMD_MARK, 16'd0, 11'd1024, 0);
    push_req(CMD_CHECK, 16'd0, 11'd1024, 0);
    push_req(CMD_UNMARK, 16'd3, 11'd10, 2);
    push_req(CMD_CHECK, 16'd0, 11'd16, 0);
    push_req(CMD_MARK, 16'hFFFF, 11'd1, 0);
    push_req(CMD_CHECK, 16'hFFFF, 11'd1, 1);
    push_req(CMD_CHECK, 16'hFFFF, 11'd2, 0);
    push_req(CMD_MARK, 16'd65000, 11'd1024, 0);
    push_req(CMD_CHECK, 16'd64512, 11'd1024, 3);
    push_req(CMD_MARK, 16'd0, 11'd1025, 0);
    push_req(CMD_UNKNOWN, 16'd0, 11'h7FF, 0);
    push_req(CMD_UNKNOWN, 16'd100, 11'd50, 0);
    push_req(CMD_CHECK, 16'd100, 11'd50, 0);
    push_req(CMD_UNMARK, 16'd5, 11'd1, 0);
    push_req(CMD_MARK, 16'd7, 11'd2, 1);
    push_req(CMD_CHECK, 16'd0, 11'd12, 0);
    push_req(CMD_UNMARK, 16'd0, 11'd1024, 0);
    push_req(CMD_CHECK, 16'd0, 11'd1024, 0);
    push_req(CMD_MARK, 16'd12345, 11'd77, 0);
    push_req(CMD_UNMARK, 16'd12350, 11'd3, 0);
    push_req(CMD_CHECK, 16'd12340, 11'd100, 0);
    push_req(CMD_UNMARK, 16'hFFFF, 11'd0, 0);
    drain_results();

    window_base = 0;
    burst_left = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) window_base = $urandom_range(0, SPACE_BYTES - 2048);
      if (i == 900) drain_results();

      r = $urandom_range(0, 99);
      if (r < 3) cmd = CMD_UNKNOWN;
      else if (r < 42) cmd = CMD_CHECK;
      else if (r < 76) cmd = CMD_MARK;
      else cmd = CMD_UNMARK;

      r = $urandom_range(0, 99);
      if (r < 55) size = SIZE_W'($urandom_range(0, 40));
      else if (r < 80) size = SIZE_W'($urandom_range(41, 300));
      else if (r < 92) size = SIZE_W'($urandom_range(301, DEF_MAX_SIZE));
      else if (r < 96) size = SIZE_W'(DEF_MAX_SIZE);
      else size = SIZE_W'($urandom_range(DEF_MAX_SIZE + 1, 2047));

      r = $urandom_range(0, 99);
      if (r < 85) addr = ADDR_W'(window_base + int'($urandom_range(0, 2047)));
      else if (r < 95) addr = ADDR_W'(SPACE_BYTES - int'($urandom_range(1, 1200)));
      else addr = ADDR_W'($urandom_range(0, SPACE_BYTES - 1));

      burst_left--;
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        burst_left = $urandom_range(1, 60);
      end else begin
        gap = 0;
      end
      push_req(cmd, addr, size, gap);
    end

    drain_results();
    repeat (150) @(posedge clk);

    $display("Run covered %0d checks, %0d marks, %0d unmarks, %0d rejected ranges",
             sb.n_checks, sb.n_marks, sb.n_unmarks, sb.n_rejects);
    $display("and %0d unknown commands; %0d results compared, %0d mismatches",
             sb.n_unknown, sb.n_results, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
